>>> rtl/core/rea_pkg.sv
// ----------------------------------------------------------------------------
// rea_pkg
// Shared widths, constants, stage types and the arctangent table of the
// elevation angle pipeline.
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int CW = 47;
    localparam int AW = 26;
    localparam int ZW = 41;
    localparam int TOP_BIT = 40;
    localparam int TABLE_LEN = 32;
    localparam int ARCTAN_STEPS_DEF = 16;
    localparam logic [15:0] KINV_Q16 = 16'd39797;
    localparam logic [14:0] RIGHT_ANGLE_Q8 = 15'd23040;

    localparam logic [2:0] REG_VIEW_X  = 3'd0;
    localparam logic [2:0] REG_VIEW_Y  = 3'd1;
    localparam logic [2:0] REG_VIEW_Z  = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;

    typedef struct packed {
        logic degen;
        logic neg;
        logic zero_z;
        logic zero_h;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] a;
        logic [ZW-1:0]        z;
        side_t                side;
    } cord_t;

    function automatic logic signed [AW-1:0] atan_q16(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58665;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/rea_cordic_stage.sv
// ----------------------------------------------------------------------------
// rea_cordic_stage
// One registered vectoring rotation with its valid bit and stall handling.
// ----------------------------------------------------------------------------
module rea_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rea_pkg::cord_t in_data,
    input  logic           down_en,
    output logic           out_valid,
    output rea_pkg::cord_t out_data,
    output logic           up_en
);

    logic           valid_reg;
    rea_pkg::cord_t data_reg;
    rea_pkg::cord_t data_next;

    assign up_en = !valid_reg || down_en;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb
    begin
        data_next = in_data;
        if (!in_data.y[rea_pkg::CW-1])
        begin
            data_next.x = in_data.x + (in_data.y >>> SHIFT);
            data_next.y = in_data.y - (in_data.x >>> SHIFT);
            data_next.a = in_data.a + rea_pkg::atan_q16(SHIFT);
        end
        else
        begin
            data_next.x = in_data.x - (in_data.y >>> SHIFT);
            data_next.y = in_data.y + (in_data.x >>> SHIFT);
            data_next.a = in_data.a - rea_pkg::atan_q16(SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/core/ray_elevation_angle.sv
// ----------------------------------------------------------------------------
// ray_elevation_angle
// Elevation angle of a voxel centre seen from a configured viewpoint.
// ----------------------------------------------------------------------------
// Input words carry a voxel centre on the s_ channel; each one yields one
// result word on the m_ channel, in order: the elevation in signed Q7.8
// degrees and a flag for a centre equal to the viewpoint. The viewpoint and
// voxel sizes are set through the write port; the user must write them only
// while the block is idle, which the block itself does not enforce. N is
// ARCTAN_STEPS capped at 32. One word is taken every cycle while the receiver
// keeps up; the two chains of N rotation stages set the depth.
// Each stage holds a valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver only blocks the stages that are
// full and bubbles are squeezed out. Reset clears all valid bits and sets
// the registers to viewpoint zero and unit voxel sizes.
// ----------------------------------------------------------------------------
module ray_elevation_angle #(
    parameter int ARCTAN_STEPS = rea_pkg::ARCTAN_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // center_x, center_y, center_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // elevation
    output logic        m_tuser    // degenerate
);

    localparam int N = (ARCTAN_STEPS > rea_pkg::TABLE_LEN) ? rea_pkg::TABLE_LEN
                                                           : ARCTAN_STEPS;
    localparam int CW = rea_pkg::CW;
    localparam int AW = rea_pkg::AW;
    localparam int ZW = rea_pkg::ZW;

    logic signed [15:0] view_x_reg, view_y_reg, view_z_reg;
    logic [15:0]        scale_x_reg, scale_y_reg, scale_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg  <= '0;
            view_y_reg  <= '0;
            view_z_reg  <= '0;
            scale_x_reg <= 16'd4096;
            scale_y_reg <= 16'd4096;
            scale_z_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rea_pkg::REG_VIEW_X:  view_x_reg  <= cfg_data;
                rea_pkg::REG_VIEW_Y:  view_y_reg  <= cfg_data;
                rea_pkg::REG_VIEW_Z:  view_z_reg  <= cfg_data;
                rea_pkg::REG_SCALE_X: scale_x_reg <= cfg_data;
                rea_pkg::REG_SCALE_Y: scale_y_reg <= cfg_data;
                rea_pkg::REG_SCALE_Z: scale_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m1_v_reg, m2_v_reg, o_v_reg;
    logic en1, en2, en3, en4, en5, en_m1, en_m2, en_out;
    logic c1_en [0:N];
    logic c2_en [0:N];
    logic c1_v [0:N];
    logic c2_v [0:N];
    rea_pkg::cord_t c1_d [0:N];
    rea_pkg::cord_t c2_d [0:N];

    assign en_out = !o_v_reg || m_tready;
    assign c2_en[N] = en_out;
    assign en_m2 = !m2_v_reg || c2_en[0];
    assign en_m1 = !m1_v_reg || en_m2;
    assign c1_en[N] = en_m1;
    assign en5 = !v5_reg || c1_en[0];
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg   <= s_tvalid;
            if (en2)    v2_reg   <= v1_reg;
            if (en3)    v3_reg   <= v2_reg;
            if (en4)    v4_reg   <= v3_reg;
            if (en5)    v5_reg   <= v4_reg;
            if (en_m1)  m1_v_reg <= c1_v[N];
            if (en_m2)  m2_v_reg <= m1_v_reg;
            if (en_out) o_v_reg  <= c2_v[N];
        end
    end

    // Stage 1: deltas and their magnitudes.
    logic signed [16:0] dx_next, dy_next, dz_next;
    logic [15:0] adx_reg, ady_reg, adz_reg;
    logic [15:0] adx_next, ady_next, adz_next;
    logic degen1_reg, neg1_reg;

    always_comb
    begin
        dx_next = {s_tdata[15], s_tdata[15:0]} - {view_x_reg[15], view_x_reg};
        dy_next = {s_tdata[31], s_tdata[31:16]} - {view_y_reg[15], view_y_reg};
        dz_next = {s_tdata[47], s_tdata[47:32]} - {view_z_reg[15], view_z_reg};
        adx_next = dx_next[16] ? 16'(-dx_next) : dx_next[15:0];
        ady_next = dy_next[16] ? 16'(-dy_next) : dy_next[15:0];
        adz_next = dz_next[16] ? 16'(-dz_next) : dz_next[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            adz_reg    <= adz_next;
            degen1_reg <= (dx_next == 17'sd0) && (dy_next == 17'sd0) && (dz_next == 17'sd0);
            neg1_reg   <= dz_next[16];
        end
    end

    // Stage 2: scaled magnitudes.
    logic [31:0] ax2_reg, ay2_reg, az2_reg;
    logic degen2_reg, neg2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ax2_reg    <= adx_reg * scale_x_reg;
            ay2_reg    <= ady_reg * scale_y_reg;
            az2_reg    <= adz_reg * scale_z_reg;
            degen2_reg <= degen1_reg;
            neg2_reg   <= neg1_reg;
        end
    end

    // Stage 3: largest magnitude and the special-case flags.
    logic [31:0] ax3_reg, ay3_reg, az3_reg, mx3_reg;
    logic [31:0] mxy_next, mx3_next;
    rea_pkg::side_t side3_reg;

    always_comb
    begin
        mxy_next = (ax2_reg > ay2_reg) ? ax2_reg : ay2_reg;
        mx3_next = (az2_reg > mxy_next) ? az2_reg : mxy_next;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
            az3_reg <= az2_reg;
            mx3_reg <= mx3_next;
            side3_reg.degen  <= degen2_reg;
            side3_reg.neg    <= neg2_reg;
            side3_reg.zero_z <= (az2_reg == 32'd0);
            side3_reg.zero_h <= (ax2_reg == 32'd0) && (ay2_reg == 32'd0);
        end
    end

    // Stage 4: normalizing shift amount.
    logic [31:0] ax4_reg, ay4_reg, az4_reg;
    logic [5:0]  sh4_reg;
    logic [4:0]  top_next;
    rea_pkg::side_t side4_reg;

    always_comb
    begin
        top_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mx3_reg[i])
            begin
                top_next = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            az4_reg   <= az3_reg;
            sh4_reg   <= 6'(rea_pkg::TOP_BIT) - {1'b0, top_next};
            side4_reg <= side3_reg;
        end
    end

    // Stage 5: normalized operands.
    logic [ZW-1:0] ax5_reg, ay5_reg, az5_reg;
    rea_pkg::side_t side5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ax5_reg   <= {{(ZW-32){1'b0}}, ax4_reg} << sh4_reg;
            ay5_reg   <= {{(ZW-32){1'b0}}, ay4_reg} << sh4_reg;
            az5_reg   <= {{(ZW-32){1'b0}}, az4_reg} << sh4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign c1_v[0] = v5_reg;
    assign c1_d[0].x = signed'({{(CW-ZW){1'b0}}, ax5_reg});
    assign c1_d[0].y = signed'({{(CW-ZW){1'b0}}, ay5_reg});
    assign c1_d[0].a = '0;
    assign c1_d[0].z = az5_reg;
    assign c1_d[0].side = side5_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_mag
        rea_cordic_stage #(
            .SHIFT(k)
        ) u_stage (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(c1_v[k]),
            .in_data(c1_d[k]),
            .down_en(c1_en[k+1]),
            .out_valid(c1_v[k+1]),
            .out_data(c1_d[k+1]),
            .up_en(c1_en[k])
        );
    end

    // Gain correction of the magnitude, product then rounding.
    logic [58:0]    prod_reg;
    logic [ZW-1:0]  zm1_reg, zm2_reg;
    rea_pkg::side_t side_m1_reg, side_m2_reg;
    logic [58:0]    rnd_next;
    logic [42:0]    r_reg;

    always_ff @(posedge clk)
    begin
        if (en_m1)
        begin
            prod_reg    <= c1_d[N].x[42:0] * rea_pkg::KINV_Q16;
            zm1_reg     <= c1_d[N].z;
            side_m1_reg <= c1_d[N].side;
        end
    end

    assign rnd_next = prod_reg + 59'd32768;

    always_ff @(posedge clk)
    begin
        if (en_m2)
        begin
            r_reg       <= rnd_next[58:16];
            zm2_reg     <= zm1_reg;
            side_m2_reg <= side_m1_reg;
        end
    end

    assign c2_v[0] = m2_v_reg;
    assign c2_d[0].x = signed'({{(CW-43){1'b0}}, r_reg});
    assign c2_d[0].y = signed'({{(CW-ZW){1'b0}}, zm2_reg});
    assign c2_d[0].a = '0;
    assign c2_d[0].z = zm2_reg;
    assign c2_d[0].side = side_m2_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_ang
        rea_cordic_stage #(
            .SHIFT(k)
        ) u_stage (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(c2_v[k]),
            .in_data(c2_d[k]),
            .down_en(c2_en[k+1]),
            .out_valid(c2_v[k+1]),
            .out_data(c2_d[k+1]),
            .up_en(c2_en[k])
        );
    end

    // Output stage: rounding to Q8, saturation, special cases and sign.
    logic signed [AW:0]   t_next;
    logic signed [AW:0]   q_next;
    logic [14:0]          mag_next;
    logic signed [15:0]   elev_next;
    logic [15:0]          elev_reg;
    logic                 degen_reg;
    rea_pkg::side_t       side_o;

    always_comb
    begin
        side_o = c2_d[N].side;
        t_next = {c2_d[N].a[AW-1], c2_d[N].a} + (AW+1)'(128);
        q_next = t_next >>> 8;
        if (q_next[AW])
        begin
            mag_next = '0;
        end
        else if (q_next > signed'({{(AW-15){1'b0}}, rea_pkg::RIGHT_ANGLE_Q8}))
        begin
            mag_next = rea_pkg::RIGHT_ANGLE_Q8;
        end
        else
        begin
            mag_next = q_next[14:0];
        end
        if (side_o.zero_z)
        begin
            mag_next = '0;
        end
        else if (side_o.zero_h)
        begin
            mag_next = rea_pkg::RIGHT_ANGLE_Q8;
        end
        elev_next = side_o.neg ? -signed'({1'b0, mag_next}) : signed'({1'b0, mag_next});
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            elev_reg  <= elev_next;
            degen_reg <= side_o.degen;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata = elev_reg;
    assign m_tuser = degen_reg;

endmodule

>>> rtl/core/rea_checker.sv
// ----------------------------------------------------------------------------
// rea_checker
// Port-level checks of the elevation angle block, bound to its top level.
// ----------------------------------------------------------------------------
module rea_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result word changed.");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("Degenerate word carries a nonzero angle.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd23040) && ($signed(m_tdata) >= -16'sd23040))
        else $error("Elevation outside the right angle.");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input blocked while the output is empty.");

endmodule

bind ray_elevation_angle rea_checker u_rea_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);

>>> tb/tb_ray_elevation_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_elevation_angle
// Self-checking testbench for the elevation angle pipeline.
// ----------------------------------------------------------------------------
// Voxel centres are streamed in with random gaps and output back-pressure.
// Every accepted word is run through a bit-exact model of the two CORDIC
// chains, and the expected elevation and degenerate flag are compared in
// order with the words that come out. Viewpoint and voxel sizes are changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_ray_elevation_angle;

    localparam int LATENCY = 2 * rea_pkg::ARCTAN_STEPS_DEF + 8;

    typedef struct {
        logic [15:0] elevation;
        logic        degenerate;
    } angle_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic [15:0] view_reg [3];
    logic [15:0] scale_reg [3];
    logic [47:0] pending_centers [$];
    angle_t      expected_angles [$];
    int          errors = 0;
    int          words_checked = 0;
    int          settings_used = 0;
    bit          idle_on = 1'b1;
    bit          sink_hold = 1'b0;
    event        stall_go;

    int atan_deg [32] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58665,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1,
        0, 0, 0, 0, 0, 0, 0, 0, 0};

    ray_elevation_angle dut (.*);

    always #1 clk = ~clk;

    function automatic angle_t predict_angle(input logic [47:0] center);
        longint delta [3];
        longint mag [3];
        longint mx, x, y, nx, ny, r, a;
        int top, sh;
        angle_t res;
        for (int k = 0; k < 3; k++)
        begin
            delta[k] = longint'($signed(center[16*k +: 16])) - longint'($signed(view_reg[k]));
            mag[k] = (delta[k] < 0 ? -delta[k] : delta[k]) * longint'(scale_reg[k]);
        end
        res.degenerate = (delta[0] == 0) && (delta[1] == 0) && (delta[2] == 0);
        a = 0;
        if (mag[2] == 0)
            a = 0;
        else if (mag[0] == 0 && mag[1] == 0)
            a = 23040;
        else
        begin
            mx = mag[0] > mag[1] ? mag[0] : mag[1];
            if (mag[2] > mx)
                mx = mag[2];
            top = 0;
            while (top < 62 && (mx >>> (top + 1)) != 0)
                top++;
            sh = top < rea_pkg::TOP_BIT ? rea_pkg::TOP_BIT - top : 0;
            x = mag[0] <<< sh;
            y = mag[1] <<< sh;
            for (int i = 0; i < rea_pkg::ARCTAN_STEPS_DEF; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i); ny = y - (x >>> i);
                end
                else
                begin
                    nx = x - (y >>> i); ny = y + (x >>> i);
                end
                x = nx; y = ny;
            end
            r = (x * 39797 + 32768) >>> 16;
            x = r;
            y = mag[2] <<< sh;
            for (int i = 0; i < rea_pkg::ARCTAN_STEPS_DEF; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i); ny = y - (x >>> i); a += atan_deg[i];
                end
                else
                begin
                    nx = x - (y >>> i); ny = y + (x >>> i); a -= atan_deg[i];
                end
                x = nx; y = ny;
            end
            a = (a + 128) >>> 8;
            if (a < 0)
                a = 0;
            if (a > 23040)
                a = 23040;
        end
        if (delta[2] < 0)
            a = -a;
        res.elevation = a[15:0];
        return res;
    endfunction

    // Source: presents the next queued centre, idling at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_angles.push_back(predict_angle(s_tdata));
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_centers.size() > 0 && !(idle_on && $urandom_range(99) < 17))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_centers.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: compares each output word with the oldest expectation.
    always @(posedge clk)
    begin
        angle_t exp_a;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("unexpected word: elevation %0d", $signed(m_tdata));
                    errors++;
                end
                else
                begin
                    exp_a = expected_angles.pop_front();
                    words_checked++;
                    if (m_tdata !== exp_a.elevation)
                    begin
                        $error("elevation: expected %0d, got %0d",
                               $signed(exp_a.elevation), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== exp_a.degenerate)
                    begin
                        $error("degenerate: expected %0b, got %0b", exp_a.degenerate, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= !sink_hold && !(idle_on && $urandom_range(99) < 17);
        end
    end

    // Receiver stall: holds the output off for a counted stretch of cycles.
    initial
    begin
        @(stall_go);
        sink_hold = 1'b1;
        repeat (300) @(posedge clk);
        sink_hold = 1'b0;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < rea_pkg::REG_SCALE_X)
            view_reg[idx] = val;
        else
            scale_reg[idx - rea_pkg::REG_SCALE_X] = val;
    endtask

    task automatic wait_drained();
        while (pending_centers.size() > 0 || s_tvalid || expected_angles.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_center(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] cz);
        pending_centers.push_back({cz, cy, cx});
    endtask

    function automatic logic [15:0] near_view(input int k);
        return view_reg[k] + 16'($urandom_range(0, 64)) - 16'd32;
    endfunction

    task automatic random_phase(input int count);
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(9);
            if (mode < 5)
                add_center(16'($urandom), 16'($urandom), 16'($urandom));
            else if (mode < 7)
                add_center(near_view(0), near_view(1), near_view(2));
            else if (mode == 7)
                add_center(view_reg[0], view_reg[1], 16'($urandom));
            else if (mode == 8)
                add_center(16'($urandom), 16'($urandom), view_reg[2]);
            else
                add_center(view_reg[0], view_reg[1], view_reg[2]);
        end
    endtask

    initial
    begin
        view_reg = '{16'd0, 16'd0, 16'd0};
        scale_reg = '{16'd4096, 16'd4096, 16'd4096};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners at reset settings.
        add_center(16'h0000, 16'h0000, 16'h0000);
        add_center(16'h0000, 16'h0000, 16'h0010);
        add_center(16'h0000, 16'h0000, 16'hFFF0);
        add_center(16'h0010, 16'h0000, 16'h0000);
        add_center(16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_center(16'h8000, 16'h8000, 16'h8000);
        add_center(16'h7FFF, 16'h8000, 16'h0001);
        add_center(16'h0001, 16'h0000, 16'h7FFF);
        add_center(16'h0010, 16'h0010, 16'hFFF0);
        add_center(16'h8000, 16'h0000, 16'h7FFF);
        add_center(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_center(16'h5555, 16'hAAAA, 16'h5555);
        wait_drained();
        settings_used++;

        idle_on = 1'b0;
        random_phase(150);
        wait_drained();
        idle_on = 1'b1;

        // Extreme viewpoints and sizes.
        write_reg(rea_pkg::REG_VIEW_X, 16'h7FFF);
        write_reg(rea_pkg::REG_VIEW_Y, 16'h8000);
        write_reg(rea_pkg::REG_VIEW_Z, 16'h7FFF);
        write_reg(rea_pkg::REG_SCALE_X, 16'hFFFF);
        write_reg(rea_pkg::REG_SCALE_Y, 16'd1);
        write_reg(rea_pkg::REG_SCALE_Z, 16'hFFFF);
        settings_used++;
        add_center(16'h8000, 16'h7FFF, 16'h8000);
        add_center(16'h7FFF, 16'h8000, 16'h7FFF);
        add_center(16'h7FFF, 16'h8000, 16'h8000);
        random_phase(200);
        wait_drained();

        write_reg(rea_pkg::REG_VIEW_X, 16'h8000);
        write_reg(rea_pkg::REG_VIEW_Y, 16'h7FFF);
        write_reg(rea_pkg::REG_VIEW_Z, 16'h8000);
        write_reg(rea_pkg::REG_SCALE_X, 16'd1);
        write_reg(rea_pkg::REG_SCALE_Y, 16'hFFFF);
        write_reg(rea_pkg::REG_SCALE_Z, 16'd1);
        settings_used++;
        random_phase(200);
        // Long output stall while the source keeps offering words.
        -> stall_go;
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            for (int k = 0; k < 6; k++)
                write_reg(3'(k), 16'($urandom_range(1, 65535)));
            settings_used++;
            random_phase(200);
            wait_drained();
        end

        write_reg(rea_pkg::REG_VIEW_X, 16'd0);
        write_reg(rea_pkg::REG_VIEW_Y, 16'd0);
        write_reg(rea_pkg::REG_VIEW_Z, 16'd0);
        write_reg(rea_pkg::REG_SCALE_X, 16'd4096);
        write_reg(rea_pkg::REG_SCALE_Y, 16'd4096);
        write_reg(rea_pkg::REG_SCALE_Z, 16'd4096);
        settings_used++;
        random_phase(100);
        wait_drained();

        $display("Checked %0d result words over %0d register settings,", words_checked,
                 settings_used);
        $display("including a long output stall and idle source pauses.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
